// ===== rtl/assert_macros.svh =====
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/sapq_pkg.sv =====
// constants, op codes and the entry type of the sorted array priority queue
package sapq_pkg;

	localparam int unsigned DEPTH     = 16;
	localparam int unsigned IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
	localparam int unsigned OP_W      = 3;
	localparam int unsigned FIELD_W   = 16;
	localparam int unsigned CAP_W     = 5;
	localparam int unsigned CNT_OUT_W = 5;
	localparam int unsigned CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int unsigned CAP_RESET = 16;

	localparam logic [OP_W-1:0] OP_INSERT   = 3'd0;
	localparam logic [OP_W-1:0] OP_REMOVE   = 3'd1;
	localparam logic [OP_W-1:0] OP_DELETE   = 3'd2;
	localparam logic [OP_W-1:0] OP_CONTAINS = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR    = 3'd4;

	typedef struct packed {
		logic [FIELD_W-1:0] key;
		logic [FIELD_W-1:0] pri;
		logic [FIELD_W-1:0] seq;
	} entry_t;

	localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

// ===== rtl/sapq_ram.sv =====
// generic single write port ram with registered read
module sapq_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                           wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                           rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== rtl/sorted_array_priority_queue.sv =====
// top level of the sorted array priority queue
//
//  channel | signals                                        | direction
//  cfg     | cfg_valid cfg_ready cfg_data                   | in, capacity write
//  in      | in_valid in_stall op key priority_req seq      | in, one op per beat
//  out     | out_valid out_stall ok out_* count full_res    | out, one result per beat
//          | head_valid head_key head_priority head_seq     |
//
// an op walks the list of held entries through the one read port of the slot ram:
// insert shifts entries up one per cycle, remove/delete/contains stream every entry once
// clear, unused ops and a refused insert go straight to the head read; every op ends with a read of slot 0
// reset empties the queue and sets capacity to 16; slot contents are left as they are
// a finished result waits in the output register while the next op is taken
`include "assert_macros.svh"

module sorted_array_priority_queue (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [sapq_pkg::CAP_W-1:0]      cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [sapq_pkg::OP_W-1:0]       op,
	input  logic [sapq_pkg::FIELD_W-1:0]    key,
	input  logic [sapq_pkg::FIELD_W-1:0]    priority_req,
	input  logic [sapq_pkg::FIELD_W-1:0]    seq,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            ok,
	output logic [sapq_pkg::FIELD_W-1:0]    out_key,
	output logic [sapq_pkg::FIELD_W-1:0]    out_priority,
	output logic [sapq_pkg::FIELD_W-1:0]    out_seq,
	output logic [sapq_pkg::CNT_OUT_W-1:0]  count,
	output logic                            full_res,
	output logic                            head_valid,
	output logic [sapq_pkg::FIELD_W-1:0]    head_key,
	output logic [sapq_pkg::FIELD_W-1:0]    head_priority,
	output logic [sapq_pkg::FIELD_W-1:0]    head_seq
);

	import sapq_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_INS   = 3'd1;
	localparam logic [2:0] S_INSW  = 3'd2;
	localparam logic [2:0] S_PUT   = 3'd3;
	localparam logic [2:0] S_SCAN  = 3'd4;
	localparam logic [2:0] S_HEAD  = 3'd5;
	localparam logic [2:0] S_HWAIT = 3'd6;

	logic [2:0]         state_q;
	logic [CNT_W-1:0]   occ_q;
	logic [CAP_W-1:0]   cap_q;
	logic [OP_W-1:0]    op_q;
	entry_t             new_q;
	logic [CNT_W-1:0]   idx_q;
	logic [CNT_W-1:0]   rcnt_q;
	logic [CNT_W-1:0]   w_q;
	logic               dv_s1;
	logic [CNT_W-1:0]   i_s1;
	logic               ok_pend_q;
	logic               found_q;
	entry_t             rem_q;

	logic               out_valid_q;
	logic               ok_q;
	entry_t             out_ent_q;
	logic [CNT_OUT_W-1:0] count_q;
	logic               full_q;
	logic               head_valid_q;
	entry_t             head_q;

	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	entry_t             wr_data;
	logic [IDX_W-1:0]   rd_addr;
	entry_t             rd_data;

	logic [CNT_W-1:0]   idx_m1;
	logic [CNT_W-1:0]   idx_m2;
	logic               less;
	logic               drop;
	logic               key_hit;
	logic               scan_more;
	logic               fits;
	logic               out_load;
	logic [CMP_W-1:0]   eff_cap;
	logic [CMP_W-1:0]   cap_ext;
	logic [CMP_W-1:0]   occ_ext;

	sapq_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH)
	) u_slots (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);

	assign cap_ext = CMP_W'(cap_q);
	assign occ_ext = CMP_W'(occ_q);
	assign eff_cap = (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;
	assign fits    = (occ_ext < eff_cap);

	assign idx_m1    = idx_q - CNT_W'(1);
	assign idx_m2    = idx_q - CNT_W'(2);
	assign less      = (new_q.pri < rd_data.pri) ||
	                   ((new_q.pri == rd_data.pri) && (new_q.seq < rd_data.seq));
	assign key_hit   = (rd_data.key == new_q.key);
	// remove drops slot 0, delete drops every key and priority match
	assign drop      = (op_q == OP_REMOVE) ? (i_s1 == '0)
	                                       : (key_hit && (rd_data.pri == new_q.pri));
	assign scan_more = (rcnt_q < occ_q);
	assign out_load  = (state_q == S_HWAIT) && (!out_valid_q || !out_stall);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q[IDX_W-1:0];
		wr_data = new_q;
		rd_addr = '0;
		unique case (state_q)
			S_INS: begin
				rd_addr = idx_m1[IDX_W-1:0];
			end
			S_INSW: begin
				wr_en = 1'b1;
				if (less) begin
					wr_data = rd_data;
					rd_addr = idx_m2[IDX_W-1:0];
				end
			end
			S_PUT: begin
				wr_en = 1'b1;
			end
			S_SCAN: begin
				rd_addr = rcnt_q[IDX_W-1:0];
				wr_addr = w_q[IDX_W-1:0];
				wr_data = rd_data;
				wr_en   = dv_s1 && !drop && (op_q != OP_CONTAINS) && (w_q != i_s1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			occ_q        <= '0;
			cap_q        <= CAP_W'(CAP_RESET);
			op_q         <= '0;
			new_q        <= '0;
			idx_q        <= '0;
			rcnt_q       <= '0;
			w_q          <= '0;
			dv_s1        <= 1'b0;
			i_s1         <= '0;
			ok_pend_q    <= 1'b0;
			found_q      <= 1'b0;
			rem_q        <= '0;
			out_valid_q  <= 1'b0;
			ok_q         <= 1'b0;
			out_ent_q    <= '0;
			count_q      <= '0;
			full_q       <= 1'b0;
			head_valid_q <= 1'b0;
			head_q       <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end

			if (out_valid_q && !out_stall && !out_load) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q      <= op;
						new_q     <= '{key: key, pri: priority_req, seq: seq};
						ok_pend_q <= 1'b0;
						found_q   <= 1'b0;
						rcnt_q    <= '0;
						w_q       <= '0;
						dv_s1     <= 1'b0;
						idx_q     <= occ_q;
						case (op) inside
							OP_INSERT: begin
								if (!fits) begin
									state_q <= S_HEAD;
								end else if (occ_q == '0) begin
									state_q <= S_PUT;
								end else begin
									state_q <= S_INS;
								end
							end
							OP_REMOVE, OP_DELETE, OP_CONTAINS: begin
								state_q <= S_SCAN;
							end
							OP_CLEAR: begin
								occ_q   <= '0;
								state_q <= S_HEAD;
							end
							default: begin
								state_q <= S_HEAD;
							end
						endcase
					end
				end
				S_INS: begin
					state_q <= S_INSW;
				end
				S_INSW: begin
					if (less) begin
						// entry below moved up, keep walking down
						idx_q <= idx_m1;
						if (idx_m1 == '0) begin
							state_q <= S_PUT;
						end
					end else begin
						occ_q     <= occ_q + CNT_W'(1);
						ok_pend_q <= 1'b1;
						state_q   <= S_HEAD;
					end
				end
				S_PUT: begin
					occ_q     <= occ_q + CNT_W'(1);
					ok_pend_q <= 1'b1;
					state_q   <= S_HEAD;
				end
				S_SCAN: begin
					dv_s1 <= scan_more;
					i_s1  <= rcnt_q;
					if (scan_more) begin
						rcnt_q <= rcnt_q + CNT_W'(1);
					end
					if (dv_s1) begin
						if (op_q == OP_CONTAINS) begin
							if (key_hit) begin
								found_q <= 1'b1;
							end
						end else if (!drop) begin
							w_q <= w_q + CNT_W'(1);
						end else if (op_q == OP_REMOVE) begin
							rem_q <= rd_data;
						end
					end
					if (!scan_more && !dv_s1) begin
						if (op_q == OP_CONTAINS) begin
							ok_pend_q <= found_q;
						end else begin
							ok_pend_q <= (w_q < occ_q);
							occ_q     <= w_q;
						end
						state_q <= S_HEAD;
					end
				end
				S_HEAD: begin
					state_q <= S_HWAIT;
				end
				S_HWAIT: begin
					if (out_load) begin
						out_valid_q  <= 1'b1;
						ok_q         <= ok_pend_q;
						out_ent_q    <= ((op_q == OP_REMOVE) && ok_pend_q) ? rem_q : '0;
						count_q      <= CNT_OUT_W'(occ_q);
						full_q       <= !fits;
						head_valid_q <= (occ_q != '0);
						head_q       <= (occ_q != '0) ? rd_data : '0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign ok            = ok_q;
	assign out_key       = out_ent_q.key;
	assign out_priority  = out_ent_q.pri;
	assign out_seq       = out_ent_q.seq;
	assign count         = count_q;
	assign full_res      = full_q;
	assign head_valid    = head_valid_q;
	assign head_key      = head_q.key;
	assign head_priority = head_q.pri;
	assign head_seq      = head_q.seq;

	`ASSERT_ALWAYS(a_occ_in_range, occ_q <= CNT_W'(DEPTH), "occupancy above depth")
	`ASSERT_IMP(a_compact_behind, (state_q == S_SCAN) && dv_s1, w_q <= i_s1,
		"compaction write passed read")
	`ASSERT_IMP(a_head_matches_count, out_valid_q, head_valid_q == (count_q != '0),
		"head valid disagrees with count")
	`ASSERT_NEXT(a_result_waits, (state_q == S_HWAIT) && out_valid_q && out_stall,
		state_q == S_HWAIT, "result overwrote a held beat")

endmodule
